### rtl/k_way_merge_unit_macros.svh
// ----------------------------------------------------------------------------
// k_way_merge_unit assertion macros
// Shared concurrent assertion forms for the merge unit.
// ----------------------------------------------------------------------------
`ifndef K_WAY_MERGE_UNIT_MACROS_SVH
`define K_WAY_MERGE_UNIT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define KWM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define KWM_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### rtl/kwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg
// Types and codes shared by the merge unit and its lane cells.
// ----------------------------------------------------------------------------
package kwm_pkg;

   localparam int CMD_W     = 2;
   localparam int LANE_W    = 3;
   localparam int KEY_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int RUN_W     = 4;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_START  = 2'd0,
      CMD_RECORD = 2'd1,
      CMD_END    = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RUNS_IN_USE = 1'b0,
      REG_DESCENDING  = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic tok;
      logic all_ready;
      logic any_head;
   } cand_type;

   typedef struct packed {
      logic              start;
      logic              rec;
      logic              fin;
      logic              clr;
      logic [LANE_W-1:0] lane;
      logic [LANE_W-1:0] clr_lane;
   } ctrl_type;

endpackage

### rtl/k_way_merge_unit.sv
`timescale 1ns / 1ps
// A new input word is taken only once the last one is through: the best-head
// candidate walks the row of lane cells one lane per cycle, then the result is
// registered. A result word waiting on rsp_stall holds the unit in emit, so it
// stalls the next request as well.
// Reset (synchronous, active high) clears all heads, end flags, the done flag
// and the handshakes; runs_in_use returns to 8 and descending to 0.
// ----------------------------------------------------------------------------
// k_way_merge_unit
// Merges up to MAX_RUNS sorted runs through a row of lane cells.
// ----------------------------------------------------------------------------
`include "k_way_merge_unit_macros.svh"

module k_way_merge_unit #(
   parameter int MAX_RUNS     = 8,
   parameter int KEY_BITS     = 32,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kwm_pkg::CMD_W-1:0]         req_cmd,
   input  logic [kwm_pkg::LANE_W-1:0]        req_lane,
   input  logic [kwm_pkg::KEY_W-1:0]         req_key,
   input  logic [kwm_pkg::PAYLOAD_W-1:0]     req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [kwm_pkg::KEY_W-1:0]         rsp_out_key,
   output logic [kwm_pkg::PAYLOAD_W-1:0]     rsp_out_payload,
   output logic [kwm_pkg::LANE_W-1:0]        rsp_source_lane,
   output logic                              rsp_done_res,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kwm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kwm_pkg::RUN_W-1:0]         csr_data
);
   import kwm_pkg::*;

   localparam int IDX_W = $clog2(MAX_RUNS);
   localparam int CAP   = (MAX_RUNS < 15) ? MAX_RUNS : 15;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [RUN_W-1:0]        runs_ff;
   logic                    desc_ff;
   logic [RUN_W-1:0]        runs_n;
   logic                    merge_done_ff, merge_done_in;
   logic                    seed_ff;
   logic                    accept, out_free, emit_go, emit_rec, emit_done;
   ctrl_type                ctrl;

   cand_type                chain_flags   [MAX_RUNS+1];
   logic [KEY_BITS-1:0]     chain_key     [MAX_RUNS+1];
   logic [PAYLOAD_BITS-1:0] chain_payload [MAX_RUNS+1];
   logic [IDX_W-1:0]        chain_lane    [MAX_RUNS+1];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]        rsp_key_ff;
   logic [PAYLOAD_W-1:0]    rsp_payload_ff;
   logic [LANE_W-1:0]       rsp_lane_ff;
   logic                    rsp_done_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         runs_ff <= RUN_W'(8);
         desc_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RUNS_IN_USE: runs_ff <= csr_data;
            REG_DESCENDING:  desc_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (runs_ff == '0) begin
         runs_n = RUN_W'(1);
      end else if (32'(runs_ff) > 32'(CAP)) begin
         runs_n = RUN_W'(CAP);
      end else begin
         runs_n = runs_ff;
      end
   end

   // command decode
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      ctrl          = '0;
      ctrl.lane     = req_lane;
      ctrl.clr      = emit_rec;
      ctrl.clr_lane = LANE_W'(chain_lane[MAX_RUNS]);
      if (accept) begin
         case (req_cmd)
            CMD_START:  ctrl.start = 1'b1;
            CMD_RECORD: ctrl.rec   = 1'b1;
            CMD_END:    ctrl.fin   = 1'b1;
            default: ;
         endcase
      end
   end

   // row of lane cells
   assign chain_flags[0]   = '{tok: seed_ff, all_ready: 1'b1, any_head: 1'b0};
   assign chain_key[0]     = '0;
   assign chain_payload[0] = '0;
   assign chain_lane[0]    = '0;

   for (genvar g = 0; g < MAX_RUNS; g++) begin : g_cell
      kwm_cell #(
         .LANE         (g),
         .KEY_BITS     (KEY_BITS),
         .PAYLOAD_BITS (PAYLOAD_BITS),
         .IDX_W        (IDX_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .runs_n      (runs_n),
         .descending  (desc_ff),
         .rec_key     (KEY_BITS'(req_key)),
         .rec_payload (PAYLOAD_BITS'(req_payload)),
         .in_flags    (chain_flags[g]),
         .in_key      (chain_key[g]),
         .in_payload  (chain_payload[g]),
         .in_lane     (chain_lane[g]),
         .out_flags   (chain_flags[g+1]),
         .out_key     (chain_key[g+1]),
         .out_payload (chain_payload[g+1]),
         .out_lane    (chain_lane[g+1])
      );
   end

   // sequencer
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_go   = (state_ff == ST_EMIT) && out_free;
   assign emit_rec  = emit_go && !merge_done_ff && chain_flags[MAX_RUNS].all_ready
                      && chain_flags[MAX_RUNS].any_head;
   assign emit_done = emit_go && !merge_done_ff && chain_flags[MAX_RUNS].all_ready
                      && !chain_flags[MAX_RUNS].any_head;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (chain_flags[MAX_RUNS].tok) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      merge_done_in = merge_done_ff;
      if (ctrl.start) begin
         merge_done_in = 1'b0;
      end else if (emit_done) begin
         merge_done_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit_rec || emit_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         merge_done_ff <= 1'b0;
         seed_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         merge_done_ff <= merge_done_in;
         seed_ff       <= accept;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (emit_rec) begin
         rsp_key_ff     <= KEY_W'(chain_key[MAX_RUNS]);
         rsp_payload_ff <= PAYLOAD_W'(chain_payload[MAX_RUNS]);
         rsp_lane_ff    <= LANE_W'(chain_lane[MAX_RUNS]);
         rsp_done_ff    <= 1'b0;
      end else if (emit_done) begin
         rsp_key_ff     <= '0;
         rsp_payload_ff <= '0;
         rsp_lane_ff    <= '0;
         rsp_done_ff    <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_payload = rsp_payload_ff;
   assign rsp_source_lane = rsp_lane_ff;
   assign rsp_done_res    = rsp_done_ff;

   `KWM_ASSERT(a_rsp_from_emit, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT), "result word outside emit")
   `KWM_ASSERT(a_done_zero, clock, reset,
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_key_ff == '0 && rsp_payload_ff == '0
      && rsp_lane_ff == '0), "done word carries record fields")
   `KWM_ASSERT(a_done_word, clock, reset,
      $rose(merge_done_ff) |-> (rsp_valid_ff && rsp_done_ff), "merge done without done word")
   `KWM_NEVER(a_tail_in_scan, clock, reset,
      chain_flags[MAX_RUNS].tok && (state_ff != ST_SCAN), "candidate left row outside scan")

endmodule

### rtl/kwm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_cell
// One lane: holds the run head and end flag, and folds its head into the
// best candidate walking along the row, one cell per cycle.
// ----------------------------------------------------------------------------
module kwm_cell #(
   parameter int LANE         = 0,
   parameter int KEY_BITS     = 32,
   parameter int PAYLOAD_BITS = 32,
   parameter int IDX_W        = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   input  kwm_pkg::ctrl_type              ctrl,
   input  logic [kwm_pkg::RUN_W-1:0]      runs_n,
   input  logic                           descending,
   input  logic [KEY_BITS-1:0]            rec_key,
   input  logic [PAYLOAD_BITS-1:0]        rec_payload,
   input  kwm_pkg::cand_type              in_flags,
   input  logic [KEY_BITS-1:0]            in_key,
   input  logic [PAYLOAD_BITS-1:0]        in_payload,
   input  logic [IDX_W-1:0]               in_lane,
   output kwm_pkg::cand_type              out_flags,
   output logic [KEY_BITS-1:0]            out_key,
   output logic [PAYLOAD_BITS-1:0]        out_payload,
   output logic [IDX_W-1:0]               out_lane
);
   import kwm_pkg::*;

   localparam logic [31:0]       LANE_U  = LANE;
   localparam bit                REACH   = LANE_U < (32'd1 << LANE_W);
   localparam logic [LANE_W-1:0] LANE_ID = LANE_W'(LANE);

   logic [KEY_BITS-1:0]     head_key_ff;
   logic [PAYLOAD_BITS-1:0] head_payload_ff;
   logic                    head_valid_ff, head_valid_in;
   logic                    run_ended_ff, run_ended_in;
   logic                    head_wr;
   logic                    active, hit, clr_hit, take_own, blocked;
   cand_type                cand_ff, cand_in;
   logic [KEY_BITS-1:0]     cand_key_ff;
   logic [PAYLOAD_BITS-1:0] cand_payload_ff;
   logic [IDX_W-1:0]        cand_lane_ff;

   assign active  = 32'(runs_n) > LANE_U;
   assign hit     = REACH && (ctrl.lane == LANE_ID);
   assign clr_hit = REACH && ctrl.clr && (ctrl.clr_lane == LANE_ID);

   always_comb begin
      head_valid_in = head_valid_ff;
      run_ended_in  = run_ended_ff;
      head_wr       = 1'b0;
      if (ctrl.start) begin
         head_valid_in = 1'b0;
         run_ended_in  = 1'b0;
      end else if (ctrl.rec && hit && active && !head_valid_ff && !run_ended_ff) begin
         head_valid_in = 1'b1;
         head_wr       = 1'b1;
      end else if (ctrl.fin && hit && active) begin
         run_ended_in = 1'b1;
      end
      if (clr_hit) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         run_ended_ff  <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         run_ended_ff  <= run_ended_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_wr) begin
         head_key_ff     <= rec_key;
         head_payload_ff <= rec_payload;
      end
   end

   // later lane wins ties
   always_comb begin
      take_own = 1'b0;
      if (active && head_valid_ff) begin
         if (!in_flags.any_head) begin
            take_own = 1'b1;
         end else if (descending) begin
            take_own = head_key_ff >= in_key;
         end else begin
            take_own = head_key_ff <= in_key;
         end
      end
   end

   assign blocked           = active && !head_valid_ff && !run_ended_ff;
   assign cand_in.tok       = in_flags.tok;
   assign cand_in.all_ready = in_flags.all_ready && !blocked;
   assign cand_in.any_head  = in_flags.any_head || (active && head_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
      end else begin
         cand_ff.tok <= cand_in.tok;
         if (in_flags.tok) begin
            cand_ff.all_ready <= cand_in.all_ready;
            cand_ff.any_head  <= cand_in.any_head;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_flags.tok) begin
         cand_key_ff     <= take_own ? head_key_ff : in_key;
         cand_payload_ff <= take_own ? head_payload_ff : in_payload;
         cand_lane_ff    <= take_own ? IDX_W'(LANE) : in_lane;
      end
   end

   assign out_flags   = cand_ff;
   assign out_key     = cand_key_ff;
   assign out_payload = cand_payload_ff;
   assign out_lane    = cand_lane_ff;

endmodule

### test/tb_k_way_merge_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_k_way_merge_unit
// Self-checking bench for the k-way merge unit. A cycle-free predictor tracks
// the lane heads, end flags and done flag. It works out the record or done
// word that each accepted request word should produce, and every result word
// is checked field by field against the oldest pending prediction. Directed
// cases cover key extremes, ties, ignored records and end marks, lane range
// and done handling. Random well-formed merges with noise follow, under
// several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_k_way_merge_unit;
   import kwm_pkg::*;

   localparam int MAX_LANES      = 8;
   localparam int DRAIN_CYCLES   = 2 * (MAX_LANES + 2);
   localparam int WATCHDOG_LIMIT = 3000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
      logic [LANE_W-1:0]    lane;
      logic                 done;
   } merge_out_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_cmd;
   logic [LANE_W-1:0]     req_lane;
   logic [KEY_W-1:0]      req_key;
   logic [PAYLOAD_W-1:0]  req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [KEY_W-1:0]      rsp_out_key;
   logic [PAYLOAD_W-1:0]  rsp_out_payload;
   logic [LANE_W-1:0]     rsp_source_lane;
   logic                  rsp_done_res;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [RUN_W-1:0]      csr_data;

   // predictor state
   logic [KEY_W-1:0]      hd_key[MAX_LANES];
   logic [PAYLOAD_W-1:0]  hd_payload[MAX_LANES];
   logic                  hd_full[MAX_LANES];
   logic                  lane_ended[MAX_LANES];
   logic                  merge_finished;
   logic [RUN_W-1:0]      cfg_runs;
   logic                  cfg_desc;

   merge_out_type expected_outs[$];
   int err_count       = 0;
   int words_sent      = 0;
   int results_checked = 0;
   int merges_done     = 0;
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int idle_cycles     = 0;

   k_way_merge_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_lane        (req_lane),
      .req_key         (req_key),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_payload (rsp_out_payload),
      .rsp_source_lane (rsp_source_lane),
      .rsp_done_res    (rsp_done_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int active_lanes();
      if (cfg_runs == 0) return 1;
      if (cfg_runs > MAX_LANES) return MAX_LANES;
      return int'(cfg_runs);
   endfunction

   function automatic bit merge_step(input logic [CMD_W-1:0] c, input logic [LANE_W-1:0] ln,
         input logic [KEY_W-1:0] k, input logic [PAYLOAD_W-1:0] p, output merge_out_type r);
      int n;
      int best;
      bit found;
      bit all_ready;
      bit any_head;
      n = active_lanes();
      best = 0;
      found = 0;
      all_ready = 1;
      any_head = 0;
      r = '0;
      case (c)
         CMD_START: begin
            for (int i = 0; i < MAX_LANES; i++) begin
               hd_full[i] = 1'b0;
               lane_ended[i] = 1'b0;
            end
            merge_finished = 1'b0;
         end
         CMD_RECORD: begin
            if (int'(ln) < n && !hd_full[ln] && !lane_ended[ln]) begin
               hd_key[ln] = k;
               hd_payload[ln] = p;
               hd_full[ln] = 1'b1;
            end
         end
         CMD_END: begin
            if (int'(ln) < n) lane_ended[ln] = 1'b1;
         end
         default: ;
      endcase
      if (merge_finished) return 0;
      for (int i = 0; i < n; i++) begin
         if (hd_full[i]) begin
            any_head = 1;
            if (!found) begin
               best = i;
               found = 1;
            end else if (cfg_desc) begin
               if (hd_key[i] >= hd_key[best]) best = i;
            end else begin
               if (hd_key[i] <= hd_key[best]) best = i;
            end
         end else if (!lane_ended[i]) begin
            all_ready = 0;
         end
      end
      if (!all_ready) return 0;
      if (any_head) begin
         r.key = hd_key[best];
         r.payload = hd_payload[best];
         r.lane = LANE_W'(best);
         hd_full[best] = 1'b0;
      end else begin
         r.done = 1'b1;
         merge_finished = 1'b1;
      end
      return 1;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
         input logic [31:0] want);
      err_count++;
      $display("%0t: mismatch on %s: got %h, want %h", $realtime, field, got, want);
   endtask

   task automatic send_word(input logic [CMD_W-1:0] c, input logic [LANE_W-1:0] ln,
         input logic [KEY_W-1:0] k, input logic [PAYLOAD_W-1:0] p);
      merge_out_type r;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_cmd     <= c;
      req_lane    <= ln;
      req_key     <= k;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (merge_step(c, ln, k, p, r)) expected_outs.push_back(r);
   endtask

   // sender pauses until every pending result word has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_outs.size() != 0) @(posedge clock);
   endtask

   task automatic wait_idle();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [RUN_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_RUNS_IN_USE) cfg_runs = data;
      else cfg_desc = data[0];
   endtask

   // well-formed merge: refill whichever lane is empty, with occasional noise
   task automatic run_merge(input int max_len);
      int left[MAX_LANES];
      logic [KEY_W-1:0] last[MAX_LANES];
      logic [KEY_W-1:0] step;
      logic [CMD_W-1:0] c;
      int free_lanes[$];
      int n;
      int pick;
      int sel;
      n = active_lanes();
      for (int i = 0; i < MAX_LANES; i++) begin
         left[i] = $urandom_range(max_len);
         last[i] = $urandom() >> $urandom_range(31);
         if (cfg_desc) last[i] = ~last[i];
      end
      send_word(CMD_START, LANE_W'($urandom()), $urandom(), $urandom());
      while (!merge_finished) begin
         free_lanes.delete();
         for (int i = 0; i < n; i++)
            if (!hd_full[i] && !lane_ended[i]) free_lanes.push_back(i);
         if ($urandom_range(99) < 2) wait_drained();
         if ($urandom_range(99) < 12 || free_lanes.size() == 0) begin
            sel = $urandom_range(99);
            if (sel < 3) c = CMD_START;
            else if (sel < 50) c = CMD_RECORD;
            else if (sel < 70) c = CMD_END;
            else c = CMD_UNUSED;
            send_word(c, LANE_W'($urandom()), $urandom(), $urandom());
         end else begin
            pick = free_lanes[$urandom_range(free_lanes.size() - 1)];
            if (left[pick] == 0) begin
               send_word(CMD_END, LANE_W'(pick), $urandom(), $urandom());
            end else begin
               send_word(CMD_RECORD, LANE_W'(pick), last[pick], $urandom());
               left[pick]--;
               step = ($urandom_range(3) == 0) ? '0 : ($urandom() >> $urandom_range(8, 31));
               if (cfg_desc) last[pick] = (last[pick] < step) ? '0 : last[pick] - step;
               else last[pick] = (last[pick] > ~step) ? '1 : last[pick] + step;
            end
         end
      end
      if ($urandom_range(3) == 0)
         send_word(CMD_RECORD, LANE_W'($urandom()), $urandom(), $urandom());
   endtask

   // extremes, ties, full lane, unused code, end on held head, records after done
   task automatic test_default_order();
      send_word(CMD_START, 3'd0, 32'h0, 32'h0);
      send_word(CMD_RECORD, 3'd0, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(CMD_RECORD, 3'd1, 32'h0000_0000, 32'hFFFF_FFFF);
      for (int i = 2; i < MAX_LANES; i++)
         send_word(CMD_RECORD, LANE_W'(i), 32'd5, 32'hA5A5_0000 | i);
      send_word(CMD_RECORD, 3'd0, 32'h1234, 32'h1);
      send_word(CMD_UNUSED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(CMD_END, 3'd1, 32'h0, 32'h0);
      send_word(CMD_END, 3'd7, 32'h0, 32'h0);
      send_word(CMD_END, 3'd0, 32'h0, 32'h0);
      for (int i = 2; i < MAX_LANES - 1; i++)
         send_word(CMD_END, LANE_W'(i), 32'h0, 32'h0);
      send_word(CMD_RECORD, 3'd3, 32'h55AA_55AA, 32'hAA55_AA55);
      send_word(CMD_START, 3'd0, 32'h0, 32'h0);
   endtask

   // lane range, descending ties, ended lanes, runs_in_use of zero
   task automatic test_lane_range();
      wait_idle();
      write_reg(REG_RUNS_IN_USE, 4'd3);
      write_reg(REG_DESCENDING, 4'd1);
      send_word(CMD_START, 3'd0, 32'h0, 32'h0);
      send_word(CMD_RECORD, 3'd5, 32'h77, 32'h77);
      send_word(CMD_END, 3'd7, 32'h0, 32'h0);
      send_word(CMD_RECORD, 3'd0, 32'd10, 32'h100);
      send_word(CMD_RECORD, 3'd1, 32'd10, 32'h101);
      send_word(CMD_RECORD, 3'd2, 32'd3, 32'h102);
      send_word(CMD_END, 3'd1, 32'h0, 32'h0);
      send_word(CMD_RECORD, 3'd1, 32'd99, 32'h103);
      send_word(CMD_END, 3'd0, 32'h0, 32'h0);
      send_word(CMD_END, 3'd2, 32'h0, 32'h0);
      wait_idle();
      write_reg(REG_RUNS_IN_USE, 4'd0);
      write_reg(REG_DESCENDING, 4'b1110);
      send_word(CMD_START, 3'd0, 32'h0, 32'h0);
      send_word(CMD_RECORD, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(CMD_RECORD, 3'd1, 32'h1, 32'h1);
      send_word(CMD_END, 3'd0, 32'h0, 32'h0);
      wait_idle();
      write_reg(REG_RUNS_IN_USE, 4'd15);
   endtask

   task automatic test_random_merges(input int idle, input int stall, input int quota);
      int first_word;
      logic [RUN_W-1:0] runs;
      first_word = words_sent;
      send_idle_pct = idle;
      stall_pct = stall;
      while (words_sent - first_word < quota) begin
         if ($urandom_range(2) == 0) begin
            case ($urandom_range(4))
               0: runs = 4'd1;
               1: runs = 4'd8;
               2: runs = 4'd0;
               3: runs = 4'd15;
               default: runs = RUN_W'($urandom_range(1, MAX_LANES));
            endcase
            wait_idle();
            write_reg(REG_RUNS_IN_USE, runs);
            write_reg(REG_DESCENDING, RUN_W'($urandom()));
         end
         run_merge(($urandom_range(9) == 0) ? 12 : 5);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      merge_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outs.size() == 0) begin
            report_mismatch("unexpected result word", rsp_out_key, '0);
         end else begin
            want = expected_outs.pop_front();
            results_checked++;
            if (rsp_out_key !== want.key)
               report_mismatch("out_key", rsp_out_key, want.key);
            if (rsp_out_payload !== want.payload)
               report_mismatch("out_payload", rsp_out_payload, want.payload);
            if (rsp_source_lane !== want.lane)
               report_mismatch("source_lane", 32'(rsp_source_lane), 32'(want.lane));
            if (rsp_done_res !== want.done)
               report_mismatch("done_res", 32'(rsp_done_res), 32'(want.done));
            if (want.done) merges_done++;
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d result words pending",
                  $realtime, idle_cycles, expected_outs.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = '0;
      req_lane    = '0;
      req_key     = '0;
      req_payload = '0;
      rsp_stall   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = REG_RUNS_IN_USE;
      csr_data    = '0;
      for (int i = 0; i < MAX_LANES; i++) begin
         hd_key[i]     = '0;
         hd_payload[i] = '0;
         hd_full[i]    = 1'b0;
         lane_ended[i] = 1'b0;
      end
      merge_finished = 1'b0;
      cfg_runs = 4'd8;
      cfg_desc = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_order();
      test_lane_range();
      test_random_merges(0, 0, 400);
      test_random_merges(85, 0, 350);
      test_random_merges(0, 85, 350);
      test_random_merges(9, 9, 400);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d request words; checked %0d result words, %0d of them end of merge.",
               words_sent, results_checked, merges_done);
      $display("Ran runs_in_use 0 to 15, both sort orders, under four idle/stall mixes.");
      if (err_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
